FILE: rtl/xsrr_pkg.sv
// ----------------------------------------------------------------------------
// xsrr_pkg: shared types and constants for the xorshift64 ranged generator
// request and response words, request codes, sequencer states and the
// xorshift step function
// ----------------------------------------------------------------------------
package xsrr_pkg;

	localparam int unsigned DATA_W = 64;
	localparam int unsigned TYPE_W = 2;

	// xorshift shift amounts
	localparam int unsigned SHIFT_A = 13;
	localparam int unsigned SHIFT_B = 7;
	localparam int unsigned SHIFT_C = 17;

	// one remainder bit per divider step
	localparam int unsigned DIV_STEPS = DATA_W;
	localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

	localparam logic [DATA_W-1:0] SEED_RESET = DATA_W'(1);

	// request codes
	localparam logic [TYPE_W-1:0] REQ_FRAC  = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_BOUND = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_RANGE = 2'd2;

	typedef struct packed {
		logic [TYPE_W-1:0] req_type;
		logic [DATA_W-1:0] first_value;
		logic [DATA_W-1:0] second_value;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0] result_value;
		logic              error_flag;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADV,
		ST_DIV,
		ST_ADD,
		ST_DONE
	} state_t;

	// control strobes from the sequencer decode
	typedef struct packed {
		logic ld_req;
		logic adv;
		logic div_step;
		logic add;
		logic out_try;
	} ctrl_t;

	function automatic logic [DATA_W-1:0] xorshift_next(input logic [DATA_W-1:0] s);
		logic [DATA_W-1:0] x;
		x = s;
		x = x ^ (x << SHIFT_A);
		x = x ^ (x >> SHIFT_B);
		x = x ^ (x << SHIFT_C);
		return x;
	endfunction

endpackage

FILE: rtl/xorshift64_ranged_random.sv
// ----------------------------------------------------------------------------
// xorshift64_ranged_random: xorshift64 generator with bound and range modes
// fraction words straight from the generator, modulo-bound and lower/upper range
// words from one shared restoring remainder unit
// ----------------------------------------------------------------------------
// steps: accept while idle, advance the generator unless the word is rejected, then for
//   bound and range words that pass, 64 remainder steps (one bit per cycle) and the add
// throughput: one word at a time, set by the 64-step remainder loop over the
//   single 66-bit subtractor; a finished word waits in the output register
//   while the next one is taken, and no request is taken before that
// reset: seed register and generator state go to 1, sequencer idle, no word
//   pending at the output
module xorshift64_ranged_random (
	input  logic                       clk,
	input  logic                       arst_n,
	// seed register
	input  logic                       cfg_wr_en,
	input  logic [xsrr_pkg::DATA_W-1:0] cfg_wr_data,
	// request channel
	input  logic                       req_valid,
	output logic                       req_stall,
	input  xsrr_pkg::req_t             req,
	// response channel
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output xsrr_pkg::rsp_t             rsp
);

	localparam int unsigned W = xsrr_pkg::DATA_W;

	xsrr_pkg::state_t state_q, state_d;
	xsrr_pkg::ctrl_t  ctrl;

	logic [W-1:0]                 seed_q;
	logic [W-1:0]                 gen_q;
	xsrr_pkg::req_t               req_q;
	logic [W-1:0]                 num_q;      // dividend, shifted out msb first
	logic [W-1:0]                 div_q;      // divisor (bound or range width)
	logic [W-1:0]                 off_q;      // lower end added after the remainder
	logic [W-1:0]                 rem_q;      // partial remainder
	logic [xsrr_pkg::CNT_W-1:0]   cnt_q;
	logic [W-1:0]                 res_q;
	logic                         err_q;
	xsrr_pkg::rsp_t               rsp_q;
	logic                         rsp_valid_q;

	logic                         accept;
	logic                         out_free;
	logic                         last_step;
	logic                         req_err;
	logic                         is_frac;
	logic [W-1:0]                 gen_next;
	logic [W-1:0]                 seed_in;
	logic [W:0]                   trial;      // shifted remainder, one bit wider
	logic [W+1:0]                 diff;       // trial minus divisor, sign on top

	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign last_step = (cnt_q == xsrr_pkg::CNT_W'(xsrr_pkg::DIV_STEPS - 1));
	assign gen_next  = xsrr_pkg::xorshift_next(gen_q);
	// a zero seed would lock the generator at zero
	assign seed_in   = (cfg_wr_data == '0) ? xsrr_pkg::SEED_RESET : cfg_wr_data;
	assign is_frac   = (req_q.req_type == xsrr_pkg::REQ_FRAC);

	// rejected words: zero bound, empty or inverted range, unused request code
	always_comb begin
		case (req_q.req_type)
			xsrr_pkg::REQ_FRAC:  req_err = 1'b0;
			xsrr_pkg::REQ_BOUND: req_err = (req_q.first_value == '0);
			xsrr_pkg::REQ_RANGE: req_err = (req_q.second_value <= req_q.first_value);
			default:             req_err = 1'b1;
		endcase
	end

	// shared remainder unit: shift in the next dividend bit, subtract if it fits
	assign trial = {rem_q, num_q[W-1]};
	assign diff  = {1'b0, trial} - {2'b00, div_q};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			xsrr_pkg::ST_IDLE: begin
				if (req_valid) state_d = xsrr_pkg::ST_ADV;
			end
			xsrr_pkg::ST_ADV: begin
				if (req_err || is_frac) state_d = xsrr_pkg::ST_DONE;
				else                    state_d = xsrr_pkg::ST_DIV;
			end
			xsrr_pkg::ST_DIV: begin
				if (last_step) state_d = xsrr_pkg::ST_ADD;
			end
			xsrr_pkg::ST_ADD: begin
				state_d = xsrr_pkg::ST_DONE;
			end
			xsrr_pkg::ST_DONE: begin
				if (out_free) state_d = xsrr_pkg::ST_IDLE;
			end
			default: begin
				state_d = xsrr_pkg::ST_IDLE;
			end
		endcase
	end

	// output decode
	always_comb begin
		ctrl      = '0;
		req_stall = 1'b1;
		case (state_q)
			xsrr_pkg::ST_IDLE: begin
				req_stall   = 1'b0;
				ctrl.ld_req = 1'b1;
			end
			xsrr_pkg::ST_ADV:  ctrl.adv      = 1'b1;
			xsrr_pkg::ST_DIV:  ctrl.div_step = 1'b1;
			xsrr_pkg::ST_ADD:  ctrl.add      = 1'b1;
			xsrr_pkg::ST_DONE: ctrl.out_try  = 1'b1;
			default:           ctrl          = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= xsrr_pkg::ST_IDLE;
			seed_q      <= xsrr_pkg::SEED_RESET;
			gen_q       <= xsrr_pkg::SEED_RESET;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			// seed writes must arrive only while idle; the block does not enforce this, and a write wins over the advance
			if (cfg_wr_en) begin
				seed_q <= seed_in;
				gen_q  <= seed_in;
			end else if (ctrl.adv && !req_err) begin
				gen_q <= gen_next;
			end

			if (ctrl.adv)           cnt_q <= '0;
			else if (ctrl.div_step) cnt_q <= cnt_q + 1'b1;

			if (ctrl.out_try && out_free) rsp_valid_q <= 1'b1;
			else if (!rsp_stall)          rsp_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (ctrl.ld_req && accept) req_q <= req;

		if (ctrl.adv) begin
			num_q <= gen_next;
			rem_q <= '0;
			if (req_q.req_type == xsrr_pkg::REQ_RANGE) begin
				div_q <= req_q.second_value - req_q.first_value;
				off_q <= req_q.first_value;
			end else begin
				div_q <= req_q.first_value;
				off_q <= '0;
			end
			res_q <= (req_err || !is_frac) ? '0 : gen_next;
			err_q <= req_err;
		end

		if (ctrl.div_step) begin
			num_q <= {num_q[W-2:0], 1'b0};
			if (!diff[W+1]) rem_q <= diff[W-1:0];
			else            rem_q <= trial[W-1:0];
		end

		// remainder is below the range width, so the sum stays below the upper end
		if (ctrl.add) res_q <= off_q + rem_q;

		if (ctrl.out_try && out_free) begin
			rsp_q.result_value <= res_q;
			rsp_q.error_flag   <= err_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks

	// generator never falls into the all-zero lock-up state
	a_gen_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		gen_q != '0)
		else $error("generator state is zero");

	// partial remainder always stays below the divisor
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == xsrr_pkg::ST_DIV |-> rem_q < div_q)
		else $error("partial remainder not below divisor");

	// a rejected word always carries a zero result
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.error_flag |-> rsp.result_value == '0)
		else $error("rejected word with nonzero result");

	// an accepted request always starts with the advance step
	a_accept_adv: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> state_q == xsrr_pkg::ST_ADV)
		else $error("accepted request did not start");

endmodule
